// ----- rtl/core/hsv2rgb_pkg.sv -----
`default_nettype none

package hsv2rgb_pkg;

	localparam int unsigned HUE_FRAC_BITS   = 6;
	localparam int unsigned LEVEL_FRAC_BITS = 12;

	localparam int unsigned LEVEL_ONE   = 1 << LEVEL_FRAC_BITS;
	localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
	localparam int unsigned FULL_TURN   = 360 << HUE_FRAC_BITS;

	localparam int unsigned HUE_W   = 15;
	localparam int unsigned LEVEL_W = 13;
	localparam int unsigned RAMP_W  = 12;
	localparam int unsigned VS_W    = 25;
	localparam int unsigned NUM_W   = 36;

	// mid byte: floor((510 * num + D) / (2 * D)), D = ONE * ONE * SPAN = 15 << MID_SHIFT - 1
	localparam int unsigned MID_SCALED_W = 45;
	localparam int unsigned MID_SHIFT    = 2 * LEVEL_FRAC_BITS + HUE_FRAC_BITS + 3;
	localparam logic [MID_SCALED_W-1:0] MID_BIAS =
		MID_SCALED_W'(SECTOR_SPAN) << (2 * LEVEL_FRAC_BITS);
	localparam int unsigned MID_Y_W      = 12;
	localparam int unsigned RECIP_SHIFT  = 17;
	localparam int unsigned RECIP_15     = ((1 << RECIP_SHIFT) + 14) / 15;
	localparam int unsigned RECIP_W      = 14;

	localparam logic [2:0] SEC_RY = 3'd0;
	localparam logic [2:0] SEC_YG = 3'd1;
	localparam logic [2:0] SEC_GC = 3'd2;
	localparam logic [2:0] SEC_CB = 3'd3;
	localparam logic [2:0] SEC_BM = 3'd4;
	localparam logic [2:0] SEC_MR = 3'd5;

	typedef struct packed {
		logic [14:0] hue;
		logic [12:0] saturation;
		logic [12:0] brightness;
		logic [7:0]  white_in;
		logic [7:0]  cool_in;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white_out;
		logic [7:0] cool_out;
	} pixel_out_t;

	function automatic logic [7:0] sat8(input logic [8:0] x);
		sat8 = x[8] ? 8'hFF : x[7:0];
	endfunction

	function automatic logic [14:0] sector_base(input logic [2:0] k);
		sector_base = 15'(32'(k) * SECTOR_SPAN);
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hsv2rgb_mid_scale.sv -----
`default_nettype none

module hsv2rgb_mid_scale (
	input  wire logic                            clk,
	input  wire logic [hsv2rgb_pkg::NUM_W-1:0]   num,
	output logic      [7:0]                      mid
);

	logic [hsv2rgb_pkg::MID_SCALED_W-1:0] scaled;
	logic [hsv2rgb_pkg::MID_SCALED_W-1:0] scaled_sh;
	logic [hsv2rgb_pkg::MID_Y_W-1:0]      y_s5;
	logic [hsv2rgb_pkg::MID_Y_W+hsv2rgb_pkg::RECIP_W-1:0] prod;
	logic [hsv2rgb_pkg::MID_Y_W+hsv2rgb_pkg::RECIP_W-1:0] quot;

	// 510 * num + D, then drop the power-of-two part of 2D
	always_comb begin
		scaled = (hsv2rgb_pkg::MID_SCALED_W'(num) << 9)
			- (hsv2rgb_pkg::MID_SCALED_W'(num) << 1)
			+ hsv2rgb_pkg::MID_BIAS;
		scaled_sh = scaled >> hsv2rgb_pkg::MID_SHIFT;
	end

	always_ff @(posedge clk) begin
		y_s5 <= scaled_sh[hsv2rgb_pkg::MID_Y_W-1:0];
	end

	// divide by 15 through the reciprocal
	always_comb begin
		prod = (hsv2rgb_pkg::MID_Y_W+hsv2rgb_pkg::RECIP_W)'(y_s5)
			* (hsv2rgb_pkg::MID_Y_W+hsv2rgb_pkg::RECIP_W)'(hsv2rgb_pkg::RECIP_15);
		quot = prod >> hsv2rgb_pkg::RECIP_SHIFT;
	end

	always_ff @(posedge clk) begin
		mid <= hsv2rgb_pkg::sat8(quot[8:0]);
	end

endmodule

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_pixel_unit.sv -----
// HSV to RGB pixel converter, six-stage pipeline.
// Output: the result strobe (done) is the valid bit of the last stage and is high
// in the same cycle as the routed result on rgbw.
// Throughput: one request per clock cycle; busy stays low, the receiver cannot stall.
// Reset: arst_n clears all stage valid bits asynchronously; no result is
// strobed until a request has passed the full pipeline.
`default_nettype none

module hsv_to_rgb_pixel_unit (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire hsv2rgb_pkg::pixel_in_t  hsv,
	output logic                         done,
	output hsv2rgb_pkg::pixel_out_t      rgbw
);

	localparam int unsigned HW = hsv2rgb_pkg::HUE_W;
	localparam int unsigned LW = hsv2rgb_pkg::LEVEL_W;
	localparam int unsigned RW = hsv2rgb_pkg::RAMP_W;
	localparam int unsigned VW = hsv2rgb_pkg::VS_W;
	localparam int unsigned NW = hsv2rgb_pkg::NUM_W;

	logic [5:0] valid_q;

	logic [HW-1:0] hue_w;
	logic [2:0]    sec;
	logic [HW-1:0] rem_full;
	logic [RW-1:0] rem;
	logic [RW-1:0] ramp;
	logic [LW-1:0] sat_c;
	logic [LW-1:0] val_c;

	logic [2:0]    sec_s1, sec_s2, sec_s3, sec_s4, sec_s5, sec_s6;
	logic [RW-1:0] ramp_s1, ramp_s2;
	logic [LW-1:0] sat_s1, val_s1, val_s2, val_s3;
	logic [7:0]    white_s1, white_s2, white_s3, white_s4, white_s5, white_s6;
	logic [7:0]    cool_s1, cool_s2, cool_s3, cool_s4, cool_s5, cool_s6;
	logic [VW-1:0] vs_s2;
	logic [NW-1:0] vst_s3;
	logic [VW-1:0] offset_s3;
	logic [NW-1:0] num_s4;
	logic [7:0]    hi_s4, hi_s5, hi_s6;
	logic [7:0]    lo_s4, lo_s5, lo_s6;
	logic [7:0]    mid_s6;

	logic [NW:0]   vst_full;
	logic [VW-1:0] offset;
	logic [NW:0]   off_span;
	logic [NW:0]   num_full;
	logic [21:0]   hi_sum;
	logic [21:0]   hi_sh;
	logic [33:0]   lo_sum;
	logic [33:0]   lo_sh;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[4:0], start & ~busy};
		end
	end

	// stage 1: wrap hue, find sector and ramp weight, clamp levels
	always_comb begin
		hue_w = (hsv.hue >= HW'(hsv2rgb_pkg::FULL_TURN))
			? hsv.hue - HW'(hsv2rgb_pkg::FULL_TURN) : hsv.hue;
		if (hue_w < HW'(hsv2rgb_pkg::SECTOR_SPAN)) begin
			sec = hsv2rgb_pkg::SEC_RY;
		end else if (hue_w < HW'(2 * hsv2rgb_pkg::SECTOR_SPAN)) begin
			sec = hsv2rgb_pkg::SEC_YG;
		end else if (hue_w < HW'(3 * hsv2rgb_pkg::SECTOR_SPAN)) begin
			sec = hsv2rgb_pkg::SEC_GC;
		end else if (hue_w < HW'(4 * hsv2rgb_pkg::SECTOR_SPAN)) begin
			sec = hsv2rgb_pkg::SEC_CB;
		end else if (hue_w < HW'(5 * hsv2rgb_pkg::SECTOR_SPAN)) begin
			sec = hsv2rgb_pkg::SEC_BM;
		end else begin
			sec = hsv2rgb_pkg::SEC_MR;
		end
		rem_full = hue_w - hsv2rgb_pkg::sector_base(sec);
		rem = rem_full[RW-1:0];
		ramp = sec[0] ? RW'(hsv2rgb_pkg::SECTOR_SPAN) - rem : rem;
		sat_c = (hsv.saturation > LW'(hsv2rgb_pkg::LEVEL_ONE))
			? LW'(hsv2rgb_pkg::LEVEL_ONE) : hsv.saturation;
		val_c = (hsv.brightness > LW'(hsv2rgb_pkg::LEVEL_ONE))
			? LW'(hsv2rgb_pkg::LEVEL_ONE) : hsv.brightness;
	end

	always_ff @(posedge clk) begin
		sec_s1   <= sec;
		ramp_s1  <= ramp;
		sat_s1   <= sat_c;
		val_s1   <= val_c;
		white_s1 <= hsv.white_in;
		cool_s1  <= hsv.cool_in;
	end

	// stage 2: chroma
	always_ff @(posedge clk) begin
		vs_s2    <= VW'(val_s1) * VW'(sat_s1);
		val_s2   <= val_s1;
		ramp_s2  <= ramp_s1;
		sec_s2   <= sec_s1;
		white_s2 <= white_s1;
		cool_s2  <= cool_s1;
	end

	// stage 3: ramp term and offset
	always_comb begin
		vst_full = (NW+1)'(vs_s2) * (NW+1)'(ramp_s2);
		offset = (VW'(val_s2) << hsv2rgb_pkg::LEVEL_FRAC_BITS) - vs_s2;
	end

	always_ff @(posedge clk) begin
		vst_s3    <= vst_full[NW-1:0];
		offset_s3 <= offset;
		val_s3    <= val_s2;
		sec_s3    <= sec_s2;
		white_s3  <= white_s2;
		cool_s3   <= cool_s2;
	end

	// stage 4: mid numerator, max and min bytes
	always_comb begin
		off_span = ((NW+1)'(offset_s3) << 12) - ((NW+1)'(offset_s3) << 8);
		num_full = (NW+1)'(vst_s3) + off_span;
		hi_sum = (22'(val_s3) << 9) - (22'(val_s3) << 1) + 22'(hsv2rgb_pkg::LEVEL_ONE);
		hi_sh = hi_sum >> (hsv2rgb_pkg::LEVEL_FRAC_BITS + 1);
		lo_sum = (34'(offset_s3) << 9) - (34'(offset_s3) << 1)
			+ (34'd1 << (2 * hsv2rgb_pkg::LEVEL_FRAC_BITS));
		lo_sh = lo_sum >> (2 * hsv2rgb_pkg::LEVEL_FRAC_BITS + 1);
	end

	always_ff @(posedge clk) begin
		num_s4   <= num_full[NW-1:0];
		hi_s4    <= hsv2rgb_pkg::sat8(hi_sh[8:0]);
		lo_s4    <= hsv2rgb_pkg::sat8(lo_sh[8:0]);
		sec_s4   <= sec_s3;
		white_s4 <= white_s3;
		cool_s4  <= cool_s3;
	end

	// stages 5 and 6: round and scale the mid channel
	hsv2rgb_mid_scale u_mid (
		.clk (clk),
		.num (num_s4),
		.mid (mid_s6)
	);

	always_ff @(posedge clk) begin
		hi_s5    <= hi_s4;
		lo_s5    <= lo_s4;
		sec_s5   <= sec_s4;
		white_s5 <= white_s4;
		cool_s5  <= cool_s4;
		hi_s6    <= hi_s5;
		lo_s6    <= lo_s5;
		sec_s6   <= sec_s5;
		white_s6 <= white_s5;
		cool_s6  <= cool_s5;
	end

	// route max, mid, min to channels by sector
	always_comb begin
		rgbw.white_out = white_s6;
		rgbw.cool_out  = cool_s6;
		case (sec_s6)
			hsv2rgb_pkg::SEC_RY: begin
				rgbw.red = hi_s6;  rgbw.green = mid_s6; rgbw.blue = lo_s6;
			end
			hsv2rgb_pkg::SEC_YG: begin
				rgbw.red = mid_s6; rgbw.green = hi_s6;  rgbw.blue = lo_s6;
			end
			hsv2rgb_pkg::SEC_GC: begin
				rgbw.red = lo_s6;  rgbw.green = hi_s6;  rgbw.blue = mid_s6;
			end
			hsv2rgb_pkg::SEC_CB: begin
				rgbw.red = lo_s6;  rgbw.green = mid_s6; rgbw.blue = hi_s6;
			end
			hsv2rgb_pkg::SEC_BM: begin
				rgbw.red = mid_s6; rgbw.green = lo_s6;  rgbw.blue = hi_s6;
			end
			default: begin
				rgbw.red = hi_s6;  rgbw.green = lo_s6;  rgbw.blue = mid_s6;
			end
		endcase
	end

	assign done = valid_q[5];

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`default_nettype none

module tb;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 667;

	typedef struct {
		hsv2rgb_pkg::pixel_in_t  px;
		bit                      typed;
		hsv2rgb_pkg::pixel_out_t want;
	} stim_row_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	hsv2rgb_pkg::pixel_in_t  hsv;
	logic                    done;
	hsv2rgb_pkg::pixel_out_t rgbw;

	bit                      hold_typed;
	hsv2rgb_pkg::pixel_out_t hold_want;
	hsv2rgb_pkg::pixel_out_t want;
	hsv2rgb_pkg::pixel_out_t pending_rgbw[$];
	int         errors = 0;
	int unsigned stall_cycles = 0;
	string      field_name[5] = '{"cool_out", "white_out", "blue", "green", "red"};

	hsv_to_rgb_pixel_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.hsv    (hsv),
		.done   (done),
		.rgbw   (rgbw)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] scale_to_byte(longint unsigned num);
		longint unsigned den;
		longint unsigned q;
		den = 64'(hsv2rgb_pkg::LEVEL_ONE) * 64'(hsv2rgb_pkg::LEVEL_ONE)
			* 64'(hsv2rgb_pkg::SECTOR_SPAN);
		q = (64'd510 * num + den) / (64'd2 * den);
		return (q > 64'd255) ? 8'hFF : q[7:0];
	endfunction

	function automatic hsv2rgb_pkg::pixel_out_t hsv_to_rgbw(hsv2rgb_pkg::pixel_in_t px);
		longint unsigned hue_w;
		longint unsigned sat;
		longint unsigned val;
		longint unsigned rem;
		longint unsigned ramp;
		longint unsigned vs;
		longint unsigned offs;
		longint unsigned one;
		longint unsigned span;
		logic [2:0] sector;
		logic [7:0] hi;
		logic [7:0] mid;
		logic [7:0] lo;
		hsv2rgb_pkg::pixel_out_t res;
		one = 64'(hsv2rgb_pkg::LEVEL_ONE);
		span = 64'(hsv2rgb_pkg::SECTOR_SPAN);
		hue_w = 64'(px.hue) % 64'(hsv2rgb_pkg::FULL_TURN);
		sat = (px.saturation > hsv2rgb_pkg::LEVEL_ONE) ? one : 64'(px.saturation);
		val = (px.brightness > hsv2rgb_pkg::LEVEL_ONE) ? one : 64'(px.brightness);
		sector = 3'(hue_w / span);
		rem = hue_w % span;
		ramp = sector[0] ? span - rem : rem;
		vs = val * sat;
		offs = val * one - vs;
		hi = scale_to_byte(val * one * span);
		mid = scale_to_byte(vs * ramp + offs * span);
		lo = scale_to_byte(offs * span);
		case (sector)
			hsv2rgb_pkg::SEC_RY: begin res.red = hi;  res.green = mid; res.blue = lo;  end
			hsv2rgb_pkg::SEC_YG: begin res.red = mid; res.green = hi;  res.blue = lo;  end
			hsv2rgb_pkg::SEC_GC: begin res.red = lo;  res.green = hi;  res.blue = mid; end
			hsv2rgb_pkg::SEC_CB: begin res.red = lo;  res.green = mid; res.blue = hi;  end
			hsv2rgb_pkg::SEC_BM: begin res.red = mid; res.green = lo;  res.blue = hi;  end
			default: begin res.red = hi; res.green = lo;  res.blue = mid; end
		endcase
		res.white_out = px.white_in;
		res.cool_out = px.cool_in;
		return res;
	endfunction

	function automatic logic [12:0] rand_level();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return 13'd0;
		else if (pick < 16)
			return 13'(hsv2rgb_pkg::LEVEL_ONE);
		else if (pick < 24)
			return 13'($urandom_range(hsv2rgb_pkg::LEVEL_ONE + 1, 8191));
		return 13'($urandom_range(0, hsv2rgb_pkg::LEVEL_ONE));
	endfunction

	function automatic hsv2rgb_pkg::pixel_in_t rand_pixel();
		hsv2rgb_pkg::pixel_in_t px;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			px.hue = 15'($urandom_range(0, 32767));
		else if (pick < 25)
			px.hue = 15'($urandom_range(0, 5) * hsv2rgb_pkg::SECTOR_SPAN
				+ $urandom_range(0, 1)
				+ ($urandom_range(0, 1) ? hsv2rgb_pkg::SECTOR_SPAN - 2 : 0));
		else
			px.hue = 15'($urandom_range(0, hsv2rgb_pkg::FULL_TURN - 1));
		px.saturation = rand_level();
		px.brightness = rand_level();
		px.white_in = 8'($urandom_range(0, 255));
		px.cool_in = 8'($urandom_range(0, 255));
		return px;
	endfunction

	// hold the request until it is taken
	task automatic send_request(hsv2rgb_pkg::pixel_in_t px, bit typed,
		hsv2rgb_pkg::pixel_out_t exp_px, int idle_pct);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		hsv <= px;
		hold_typed <= typed;
		hold_want <= exp_px;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (pending_rgbw.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, rgbw);
				errors++;
			end else begin
				want = pending_rgbw.pop_front();
				for (int i = 0; i < 5; i++) begin
					if (rgbw[8*i +: 8] !== want[8*i +: 8]) begin
						$display("%0t: %s mismatch, expected %h, actual %h", $time,
							field_name[i], want[8*i +: 8], rgbw[8*i +: 8]);
						errors++;
					end
				end
			end
		end
		if (start && !busy)
			pending_rgbw.push_back(hold_typed ? hold_want : hsv_to_rgbw(hsv));
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_rgbw.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		int idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		hsv = '0;
		hold_typed = 1'b0;
		hold_want = '0;

		rows.push_back('{'{15'd0, 13'd4096, 13'd4096, 8'h00, 8'h00}, 1,
			'{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}});
		rows.push_back('{'{15'd3840, 13'd4096, 13'd4096, 8'hFF, 8'hFF}, 1,
			'{8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF}});
		rows.push_back('{'{15'd7680, 13'd4096, 13'd4096, 8'h55, 8'hAA}, 1,
			'{8'h00, 8'hFF, 8'h00, 8'h55, 8'hAA}});
		rows.push_back('{'{15'd11520, 13'd4096, 13'd4096, 8'hAA, 8'h55}, 1,
			'{8'h00, 8'hFF, 8'hFF, 8'hAA, 8'h55}});
		rows.push_back('{'{15'd15360, 13'd4096, 13'd4096, 8'h01, 8'h80}, 1,
			'{8'h00, 8'h00, 8'hFF, 8'h01, 8'h80}});
		rows.push_back('{'{15'd19200, 13'd4096, 13'd4096, 8'h80, 8'h01}, 1,
			'{8'hFF, 8'h00, 8'hFF, 8'h80, 8'h01}});
		// full turn wraps back to red
		rows.push_back('{'{15'd23040, 13'd4096, 13'd4096, 8'h12, 8'h34}, 1,
			'{8'hFF, 8'h00, 8'h00, 8'h12, 8'h34}});
		rows.push_back('{'{15'd1920, 13'd4096, 13'd4096, 8'h00, 8'h00}, 1,
			'{8'hFF, 8'h80, 8'h00, 8'h00, 8'h00}});
		rows.push_back('{'{15'd0, 13'd0, 13'd4096, 8'h7F, 8'hFE}, 1,
			'{8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hFE}});
		rows.push_back('{'{15'd0, 13'd0, 13'd0, 8'h00, 8'h00}, 1,
			'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}});
		rows.push_back('{'{15'd1000, 13'd4096, 13'd0, 8'hFF, 8'h00}, 1,
			'{8'h00, 8'h00, 8'h00, 8'hFF, 8'h00}});
		rows.push_back('{'{15'd5000, 13'd0, 13'd2048, 8'h00, 8'hFF}, 1,
			'{8'h80, 8'h80, 8'h80, 8'h00, 8'hFF}});
		rows.push_back('{'{15'd0, 13'd8191, 13'd0, 8'h0F, 8'hF0}, 1,
			'{8'h00, 8'h00, 8'h00, 8'h0F, 8'hF0}});
		rows.push_back('{'{15'd32767, 13'd4096, 13'd4096, 8'h00, 8'h00}, 0, '0});
		rows.push_back('{'{15'd23039, 13'd4096, 13'd4096, 8'h00, 8'h00}, 0, '0});
		rows.push_back('{'{15'd3839, 13'd4096, 13'd4096, 8'h00, 8'h00}, 0, '0});
		rows.push_back('{'{15'd7000, 13'd8191, 13'd4096, 8'h33, 8'hCC}, 0, '0});
		rows.push_back('{'{15'd7000, 13'd4096, 13'd8191, 8'hCC, 8'h33}, 0, '0});
		rows.push_back('{'{15'd16383, 13'd8191, 13'd8191, 8'h5A, 8'hA5}, 0, '0});
		rows.push_back('{'{15'd12345, 13'd2048, 13'd3000, 8'hA5, 8'h5A}, 0, '0});
		rows.push_back('{'{15'd20000, 13'd1, 13'd4095, 8'h00, 8'h00}, 0, '0});

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (rows[k])
			send_request(rows[k].px, rows[k].typed, rows[k].want, 8);

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 8 : (phase == 1) ? 74 : 0;
			repeat (RANDOM_PER_PHASE)
				send_request(rand_pixel(), 1'b0, '0, idle_pct);
		end

		@(negedge clk);
		start <= 1'b0;
		hold_typed <= 1'b0;

		while (pending_rgbw.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- hsv_to_rgb_pixel_unit.f -----
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_mid_scale.sv
rtl/core/hsv_to_rgb_pixel_unit.sv
sim/tb.sv
